[hdl/fbt_pkg.sv]
// shared types, codes and helpers of the flash unit busy timer
package fbt_pkg;

    localparam int NUM_UNITS = 16;
    localparam int UNIT_W    = 4;
    localparam int TAG_W     = 16;
    localparam int TIME_W    = 20;
    localparam int TYPE_W    = 3;

    // reciprocal of ten, exact for any 20-bit operand
    localparam logic [TIME_W-1:0] RECIP10 = 20'hCCCCD;
    localparam int                RECIP_SHIFT = 23;

    typedef enum logic [TYPE_W-1:0] {
        OP_READ    = 3'd0,
        OP_PROGRAM = 3'd1,
        OP_ERASE   = 3'd2,
        OP_DUMMY   = 3'd3,
        OP_TRIM    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BUSY    = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    localparam logic KIND_ISSUE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;
    localparam logic ACT_ISSUE  = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [1:0] REG_TIMING_EN = 2'd0;
    localparam logic [1:0] REG_PROGRAM   = 2'd1;
    localparam logic [1:0] REG_READ      = 2'd2;
    localparam logic [1:0] REG_ERASE     = 2'd3;

    // one unit entry of the state memory
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] target;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result item
    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [UNIT_W-1:0] unit;
        logic [TAG_W-1:0]  tag;
    } result_t;

    function automatic logic [TIME_W-1:0] div10(input logic [TIME_W-1:0] t);
        logic [2*TIME_W-1:0] prod;
        prod = (2*TIME_W)'(t) * (2*TIME_W)'(RECIP10);
        return TIME_W'(prod[2*TIME_W-1:RECIP_SHIFT]);
    endfunction

endpackage

[hdl/flash_unit_busy_timer_unit.sv]
// top level of the flash unit busy timer: issue handling, tick scan, output staging
//
//  channel  | direction | contents
//  s_*      | in        | tuser action; tdata op type, unit, tag
//  m_*      | out       | tuser kind; tdata status, done_unit, done_tag; tlast
//  apb      | in/out    | timing_enable, program/read/erase times at 0x0..0xC
//
// an issue passes through ISSUE and FIN, with a scan between them when timing is off and the unit is taken
// a tick runs a scan: one state memory read per unit, pipelined one unit a cycle while the scan does not stall
// the scan stalls only when a completion is found while a result is already held and the output register is full,
// and the last result waits for the output register in the same way
// reset clears all busy bits; unit entries are written on issue before their contents matter
// the input is taken only when the previous item has finished, including any scan
module flash_unit_busy_timer_unit
    import fbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op_type[2:0], unit[6:3], tag[22:7], zero
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], done_unit[5:2], done_tag[21:6], zero
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic              timing_en_reg;
    logic [TIME_W-1:0] program_time_reg;
    logic [TIME_W-1:0] read_time_reg;
    logic [TIME_W-1:0] erase_time_reg;

    logic [NUM_UNITS-1:0] busy_reg, busy_next;
    logic                 scan_inc_reg, scan_inc_next;
    logic [UNIT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [TYPE_W-1:0]    iss_type_reg, iss_type_next;
    logic [UNIT_W-1:0]    iss_unit_reg, iss_unit_next;
    logic [TAG_W-1:0]     iss_tag_reg, iss_tag_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 out_last_reg, out_last_next;

    logic              ram_we, ram_re;
    logic [UNIT_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    logic              cfg_wr;
    logic              push_ok;
    logic [TIME_W-1:0] op_time, op_target;
    logic              cur_busy, cur_done, cur_stall;
    logic [TIME_W-1:0] cur_elapsed;

    fbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_UNITS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TIMING_EN: prdata = {31'd0, timing_en_reg};
            REG_PROGRAM:   prdata = {12'd0, program_time_reg};
            REG_READ:      prdata = {12'd0, read_time_reg};
            REG_ERASE:     prdata = {12'd0, erase_time_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_en_reg    <= 1'b0;
            program_time_reg <= TIME_W'(200);
            read_time_reg    <= TIME_W'(50);
            erase_time_reg   <= TIME_W'(2000);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_TIMING_EN: timing_en_reg    <= pwdata[0];
                REG_PROGRAM:   program_time_reg <= pwdata[TIME_W-1:0];
                REG_READ:      read_time_reg    <= pwdata[TIME_W-1:0];
                REG_ERASE:     erase_time_reg   <= pwdata[TIME_W-1:0];
                default:       ;
            endcase
        end
    end

    // target delay: time of the op type minus a tenth of it; zero when timing is off or for other op types
    always_comb
    begin
        unique case (iss_type_reg)
            OP_READ:    op_time = read_time_reg;
            OP_PROGRAM: op_time = program_time_reg;
            OP_ERASE:   op_time = erase_time_reg;
            default:    op_time = '0;
        endcase
        if (!timing_en_reg)
        begin
            op_time = '0;
        end
        op_target = op_time - div10(op_time);
    end

    // per-unit check during a scan
    assign push_ok     = !out_valid_reg || m_tready;
    assign cur_busy    = busy_reg[chk_idx_reg];
    assign cur_elapsed = (scan_inc_reg && cur_busy && ram_rdata.elapsed != '1)
                         ? ram_rdata.elapsed + 1'b1 : ram_rdata.elapsed;
    assign cur_done    = cur_busy && (cur_elapsed >= ram_rdata.target);
    assign cur_stall   = cur_done && pend_valid_reg && !push_ok;

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        scan_inc_next   = scan_inc_reg;
        chk_idx_next    = chk_idx_reg;
        iss_type_next   = iss_type_reg;
        iss_unit_next   = iss_unit_reg;
        iss_tag_next    = iss_tag_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg;
        ram_wdata       = '{tag: ram_rdata.tag, elapsed: cur_elapsed,
                            target: ram_rdata.target};
        ram_re          = 1'b0;
        ram_raddr       = chk_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ACT_TICK)
                    begin
                        scan_inc_next = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                    else
                    begin
                        iss_type_next = s_tdata[2:0];
                        iss_unit_next = s_tdata[6:3];
                        iss_tag_next  = s_tdata[22:7];
                        state_next    = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                pend_valid_next = 1'b1;
                pend_next       = '{kind: KIND_ISSUE, status: STAT_OK,
                                    unit: iss_unit_reg, tag: iss_tag_reg};
                state_next      = ST_FIN;
                priority if (iss_type_reg > OP_TRIM)
                begin
                    pend_next.status = STAT_INVALID;
                end
                else if (busy_reg[iss_unit_reg])
                begin
                    pend_next.status = STAT_BUSY;
                end
                else
                begin
                    busy_next[iss_unit_reg] = 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = iss_unit_reg;
                    ram_wdata = '{tag: iss_tag_reg, elapsed: '0, target: op_target};
                    if (!timing_en_reg)
                    begin
                        scan_inc_next = 1'b0;
                        state_next    = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                ram_re       = 1'b1;
                ram_raddr    = '0;
                chk_idx_next = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!cur_stall)
                begin
                    ram_we = scan_inc_reg && cur_busy;
                    if (cur_done)
                    begin
                        busy_next[chk_idx_reg] = 1'b0;
                        // the held result is not the last one: send it on
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = '{kind: KIND_DONE, status: STAT_OK,
                                            unit: chk_idx_reg, tag: ram_rdata.tag};
                    end
                    if (chk_idx_reg == UNIT_W'(NUM_UNITS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = chk_idx_reg + 1'b1;
                        chk_idx_next = chk_idx_reg + 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (push_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            busy_reg       <= '0;
            scan_inc_reg   <= 1'b0;
            chk_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            scan_inc_reg   <= scan_inc_next;
            chk_idx_reg    <= chk_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_type_reg <= iss_type_next;
        iss_unit_reg <= iss_unit_next;
        iss_tag_reg  <= iss_tag_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_reg.tag, out_reg.unit, out_reg.status};

    // a completion never carries a reject status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_DONE) |-> (m_tdata[1:0] == STAT_OK))
        else $error("completion with nonzero status");

    // write-back of one unit never collides with the read of the next
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("state memory read and write on the same entry");

    // units are only taken busy by an issue
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ISSUE) |=> ($countones(busy_reg) <= $countones($past(busy_reg))))
        else $error("busy bit set outside issue");

    // every issue leaves a status result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |=> pend_valid_reg)
        else $error("issue without status result");

    // nothing is held back when the block goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("result left pending in idle");

endmodule

[hdl/fbt_ram.sv]
// generic simple dual-port ram with registered read
module fbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
